@@ rtl/core/zlvm_pkg.sv @@
// ----------------------------------------------------------------------------
// zlvm_pkg: shared types and constants of the zone locator
// Transaction structs, command codes, register indexes and controller types.
// ----------------------------------------------------------------------------
package zlvm_pkg;

	// command codes of an input transaction (value 3 is unused)
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_LOCATE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_SLACK     = 2'd1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] SLACK_RESET = 16'd1500;

	// distances and sides are divided by 64 before squaring or multiplying
	localparam int unsigned SCALE_SHIFT = 6;

	localparam int unsigned ZONE_IDS = 256;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         entry_slot;
		logic [15:0]        room_number;
		logic [7:0]         zone_number;
		logic signed [15:0] box_left;
		logic signed [15:0] box_right;
		logic signed [15:0] box_near;
		logic signed [15:0] box_far;
		logic signed [31:0] point_x;
		logic signed [31:0] point_z;
		logic               mark_visited;
	} req_item_t;

	typedef struct packed {
		logic       found;
		logic [7:0] found_slot;
		logic [7:0] found_zone;
		logic       inside_box;
		logic       zone_seen;
	} rsp_item_t;

	// one zone table entry, 88 bits
	typedef struct packed {
		logic [15:0]        room;
		logic [7:0]         zone;
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic signed [15:0] near_z;
		logic signed [15:0] far_z;
	} zone_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear_seen;
		logic start;
		logic issue;
		logic finish;
		logic locate;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/core/zone_locate_and_visit_mark.sv @@
// ----------------------------------------------------------------------------
// zone_locate_and_visit_mark: zone box locator with visited marks
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// A load, a clear or an unused command goes straight from idle to the finish
// state and answers with an all-zero result. A locate reads the zone table
// through its single read port, one entry per cycle, so it occupies the block
// for the scan of N = min(entries_in_use, TABLE_DEPTH) entries, N nonzero, plus
// the depth of the read, distance and compare pipeline and the result write;
// with N zero it goes straight to finish. A new transaction is taken while the
// previous result still waits in the output register, but its own result
// write waits, and holds the block, until that register is free. The table
// has no reset; every entry a locate scans must have been loaded. Visited bits
// clear at reset and on a clear transaction.
module zone_locate_and_visit_mark
	import zlvm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_item_t             req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_item_t             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [8:0]    entries_q;
	logic [15:0]   slack_q;
	dp_cmd_t       dp_cmd;
	dp_status_t    status;
	logic [AW-1:0] issue_addr;

	// writes to unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			slack_q   <= SLACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRIES_IN_USE: entries_q <= cfg_data[8:0];
				REG_EDGE_SLACK:     slack_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	zlvm_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_cmd       (req.cmd),
		.req_stall     (req_stall),
		.entries_in_use(entries_q),
		.status        (status),
		.dp_cmd        (dp_cmd),
		.issue_addr    (issue_addr)
	);

	zlvm_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.edge_slack(slack_q),
		.dp_cmd    (dp_cmd),
		.issue_addr(issue_addr),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ rtl/core/zlvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// zlvm_ctrl: sequencer of the zone locator
// Accepts transactions, steps the table scan, waits for the pipeline to
// drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module zlvm_ctrl
	import zlvm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256,
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_cmd,
	output logic          req_stall,
	input  logic [8:0]    entries_in_use,
	input  dp_status_t    status,
	output dp_cmd_t       dp_cmd,
	output logic [AW-1:0] issue_addr
);

	ctrl_state_t   state_q, state_nxt;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count;
	logic          locate_q;
	logic          accept;
	logic          last_issue;

	// scan no more entries than the table holds
	always_comb begin
		if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
			count = CW'(TABLE_DEPTH);
		end else begin
			count = CW'(entries_in_use);
		end
	end

	assign accept     = req_valid && (state_q == ST_IDLE);
	assign last_issue = (idx_q + CW'(1)) == count;
	assign req_stall  = (state_q != ST_IDLE);
	assign issue_addr = idx_q[AW-1:0];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_cmd == CMD_LOCATE && count != '0) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (last_issue) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		dp_cmd            = '0;
		dp_cmd.load       = accept && (req_cmd == CMD_LOAD);
		dp_cmd.clear_seen = accept && (req_cmd == CMD_CLEAR);
		dp_cmd.start      = accept && (req_cmd == CMD_LOCATE);
		dp_cmd.issue      = (state_q == ST_SCAN);
		dp_cmd.finish     = (state_q == ST_FINISH) && status.out_free;
		dp_cmd.locate     = locate_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			locate_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				idx_q    <= '0;
				locate_q <= (req_cmd == CMD_LOCATE);
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.issue |-> (idx_q < count))
		else $error("scan address past entry count");
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !status.pipe_busy)
		else $error("result taken while scan pipeline busy");
	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after result");
	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.start |=> !dp_cmd.start && (state_q != ST_IDLE))
		else $error("locate started twice");
`endif

endmodule

@@ rtl/core/zlvm_dp.sv @@
// ----------------------------------------------------------------------------
// zlvm_dp: datapath of the zone locator
// Zone table memory, visited bits, the per-entry distance and area pipeline,
// the running best and nearest candidates and the output register.
// ----------------------------------------------------------------------------
module zlvm_dp
	import zlvm_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256,
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  req_item_t     req,
	input  logic [15:0]   edge_slack,
	input  dp_cmd_t       dp_cmd,
	input  logic [AW-1:0] issue_addr,
	output dp_status_t    status,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsp_item_t     rsp
);

	localparam int unsigned GW = 28;   // scaled gap width
	localparam int unsigned SW = 11;   // scaled side width, signed
	localparam int unsigned DW = 2 * GW + 1;

	zone_entry_t        mem [TABLE_DEPTH];
	zone_entry_t        ent_s1;
	logic               vld_s1, vld_s2, vld_s3;
	logic [7:0]         slot_s1, slot_s2, slot_s3;
	logic [7:0]         zone_s2, zone_s3;

	logic [15:0]        room_q;
	logic signed [31:0] px_q, pz_q;
	logic               mark_q;
	logic [ZONE_IDS-1:0] seen_q;

	logic               match_s2, contain_s2;
	logic [GW-1:0]      gx_s2, gz_s2;
	logic signed [SW-1:0] w_s2, h_s2;

	logic               match_s3, contain_s3;
	logic [2*GW-1:0]    sqx_s3, sqz_s3;
	logic signed [2*SW-1:0] area_s3;

	logic               have_near_q, have_best_q;
	logic [DW-1:0]      near_d_q;
	logic signed [2*SW-1:0] best_area_q;
	logic [7:0]         near_slot_q, best_slot_q, near_zone_q, best_zone_q;

	logic               rsp_valid_q;
	rsp_item_t          rsp_q;
	rsp_item_t          rsp_nxt;

	logic [DW-1:0]      gap_sum;
	logic               contain;
	logic signed [33:0] px34, pz34, slack34;
	logic               hit;
	logic [7:0]         pick_slot, pick_zone;

	function automatic logic [GW-1:0] axis_gap(input logic signed [33:0] p,
			input logic signed [33:0] lo, input logic signed [33:0] hi);
		logic signed [33:0] g;
		g = '0;
		if (p < lo) begin
			g = lo - p;
		end else if (p > hi) begin
			g = p - hi;
		end
		return g[GW+SCALE_SHIFT-1:SCALE_SHIFT];
	endfunction

	// side length scaled with truncation toward zero
	function automatic logic signed [SW-1:0] scaled_side(input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		logic signed [17:0] d;
		d = 18'(hi) - 18'(lo);
		if (d < 0) d = d + 18'sd63;
		return SW'(d >>> SCALE_SHIFT);
	endfunction

	// table write and registered scan read
	always_ff @(posedge clk) begin
		if (dp_cmd.load && (32'(req.entry_slot) < 32'(TABLE_DEPTH))) begin
			mem[AW'(req.entry_slot)] <= '{room: req.room_number, zone: req.zone_number,
				left: req.box_left, right: req.box_right,
				near_z: req.box_near, far_z: req.box_far};
		end
		if (dp_cmd.issue) begin
			ent_s1 <= mem[issue_addr];
		end
	end

	assign px34    = 34'(px_q);
	assign pz34    = 34'(pz_q);
	assign slack34 = $signed({18'd0, edge_slack});

	assign contain = (px34 >= 34'(ent_s1.left) - slack34)
		&& (px34 <= 34'(ent_s1.right) + slack34)
		&& (pz34 >= 34'(ent_s1.near_z) - slack34)
		&& (pz34 <= 34'(ent_s1.far_z) + slack34);

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			room_q <= req.room_number;
			px_q   <= req.point_x;
			pz_q   <= req.point_z;
			mark_q <= req.mark_visited;
		end
		slot_s1    <= 8'(issue_addr);
		match_s2   <= (ent_s1.room == room_q);
		contain_s2 <= contain;
		gx_s2      <= axis_gap(px34, 34'(ent_s1.left), 34'(ent_s1.right));
		gz_s2      <= axis_gap(pz34, 34'(ent_s1.near_z), 34'(ent_s1.far_z));
		w_s2       <= scaled_side(ent_s1.left, ent_s1.right);
		h_s2       <= scaled_side(ent_s1.near_z, ent_s1.far_z);
		slot_s2    <= slot_s1;
		zone_s2    <= ent_s1.zone;
		match_s3   <= match_s2;
		contain_s3 <= contain_s2;
		sqx_s3     <= gx_s2 * gx_s2;
		sqz_s3     <= gz_s2 * gz_s2;
		area_s3    <= w_s2 * h_s2;
		slot_s3    <= slot_s2;
		zone_s3    <= zone_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= dp_cmd.issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign gap_sum = {1'b0, sqx_s3} + {1'b0, sqz_s3};

	// strict compares keep the first entry on a tie
	always_ff @(posedge clk) begin
		if (vld_s3 && match_s3) begin
			if (!have_near_q || gap_sum < near_d_q) begin
				near_d_q    <= gap_sum;
				near_slot_q <= slot_s3;
				near_zone_q <= zone_s3;
			end
			if (contain_s3 && (!have_best_q || area_s3 < best_area_q)) begin
				best_area_q <= area_s3;
				best_slot_q <= slot_s3;
				best_zone_q <= zone_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_near_q <= 1'b0;
			have_best_q <= 1'b0;
		end else if (dp_cmd.start) begin
			have_near_q <= 1'b0;
			have_best_q <= 1'b0;
		end else if (vld_s3 && match_s3) begin
			have_near_q <= 1'b1;
			if (contain_s3) have_best_q <= 1'b1;
		end
	end

	assign hit       = dp_cmd.locate && have_near_q;
	assign pick_slot = have_best_q ? best_slot_q : near_slot_q;
	assign pick_zone = have_best_q ? best_zone_q : near_zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (dp_cmd.clear_seen) begin
			seen_q <= '0;
		end else if (dp_cmd.finish && hit && mark_q) begin
			seen_q[pick_zone] <= 1'b1;
		end
	end

	// output register: hold until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (dp_cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		rsp_nxt = '0;
		if (hit) begin
			rsp_nxt.found      = 1'b1;
			rsp_nxt.found_slot = pick_slot;
			rsp_nxt.found_zone = pick_zone;
			rsp_nxt.inside_box = have_best_q;
			rsp_nxt.zone_seen  = mark_q | seen_q[pick_zone];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign status.pipe_busy = vld_s1 | vld_s2 | vld_s3;
	assign status.out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid        = rsp_valid_q;
	assign rsp              = rsp_q;

`ifndef NO_ASSERTIONS
	a_no_finish_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |-> !(vld_s1 || vld_s2 || vld_s3))
		else $error("result written while candidates still in flight");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled result lost or changed");
	a_best_implies_near: assert property (@(posedge clk) disable iff (!arst_n)
		have_best_q |-> have_near_q)
		else $error("containing box without nearest candidate");
`endif

endmodule
